[rtl/tmd_pkg.sv]
// ----------------------------------------------------------------------------
// tmd_pkg
// Types and constants shared by the tape marker detector.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned StepW   = 16;
  localparam int unsigned SenseW  = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned SatW    = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [SatW-1:0] SatMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_KIND    = 3'd0,
    CFG_MIN_ACTIVE       = 3'd1,
    CFG_CONFIRM_SAMPLES  = 3'd2,
    CFG_RELEASE_SAMPLES  = 3'd3,
    CFG_PAIR_DISTANCE    = 3'd4,
    CFG_PAIR_TOLERANCE   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_SINGLE = 1'b0,
    KIND_DOUBLE = 1'b1
  } marker_kind_e;

  typedef struct packed {
    logic                     opcode;
    logic [SenseW-1:0]        sensor_bits;
    logic signed [StepW-1:0]  travel_step;
  } in_req_t;

  typedef struct packed {
    logic [CountW-1:0]        active_count;
    logic                     event_flag;
    logic                     marker_kind;
    logic signed [PosW-1:0]   marker_position;
  } out_req_t;

endpackage

[rtl/tape_marker_detector.sv]
// ----------------------------------------------------------------------------
// tape_marker_detector
// Tape piece tracking and single or double marker detection over a sample
// stream with a wrapping travel position.
// ----------------------------------------------------------------------------
// Each accepted request is processed in the cycle it is accepted and its result
// appears in the output register on the next cycle. One request per cycle is
// sustained: the output register frees in the same cycle its result is taken,
// so input ready only drops while a result is held back by the consumer. The
// per-sample path is one position add followed by the center, spacing and
// timeout compares. Configuration writes take effect at once and are meant to
// happen while no request is in flight; restart requests clear the tracking
// state but keep the configuration.
module tape_marker_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tmd_pkg::in_req_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tmd_pkg::out_req_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tmd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tmd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tmd_pkg::*;

  // configuration
  logic            kind_q;
  logic [2:0]      min_act_q;
  logic [7:0]      confirm_q;
  logic [7:0]      release_q;
  logic [15:0]     dist_q;
  logic [15:0]     tol_q;

  // tracking state
  logic [PosW-1:0] progress_q, progress_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] first_q, first_d;
  logic [SatW-1:0] on_q, on_d;
  logic [SatW-1:0] off_q, off_d;
  logic            in_piece_q, in_piece_d;
  logic            await_q, await_d;
  logic            rep_q, rep_d;

  logic            out_valid_q;
  out_req_t        out_q, out_d;
  logic            accept;

  logic [CountW-1:0] count;
  logic              tape;
  logic [SatW-1:0]   on_inc, off_inc;
  logic [PosW:0]     center_sum, mid_sum;
  logic [PosW-1:0]   center, mid;
  logic signed [PosW:0]   run_diff, spacing;
  logic signed [PosW+1:0] err;
  logic [PosW+1:0]        err_abs;
  logic [16:0]            reach;
  logic                   timeout, matched;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    count = {2'b00, in_data_i.sensor_bits[0]} + {2'b00, in_data_i.sensor_bits[1]}
          + {2'b00, in_data_i.sensor_bits[2]} + {2'b00, in_data_i.sensor_bits[3]};
    tape  = count >= min_act_q;
    progress_d = progress_q + {{(PosW-StepW){in_data_i.travel_step[StepW-1]}},
                               in_data_i.travel_step};
    on_inc  = (on_q  < SatMax) ? on_q  + 8'd1 : on_q;
    off_inc = (off_q < SatMax) ? off_q + 8'd1 : off_q;

    // piece center and pair midpoint, floor of half the exact sum
    center_sum = {start_q[PosW-1], start_q} + {progress_d[PosW-1], progress_d};
    center     = center_sum[PosW:1];
    mid_sum    = {first_q[PosW-1], first_q} + {center[PosW-1], center};
    mid        = mid_sum[PosW:1];

    spacing = $signed({center[PosW-1], center}) - $signed({first_q[PosW-1], first_q});
    err     = $signed({spacing[PosW], spacing}) - $signed({18'd0, dist_q});
    err_abs = err[PosW+1] ? 34'(-err) : 34'(err);
    matched = err_abs <= {18'd0, tol_q};

    reach    = {1'b0, dist_q} + {1'b0, tol_q};
    run_diff = $signed({progress_d[PosW-1], progress_d})
             - $signed({first_q[PosW-1], first_q});
    timeout  = run_diff > $signed({16'd0, reach});

    start_d    = start_q;
    first_d    = first_q;
    on_d       = on_q;
    off_d      = off_q;
    in_piece_d = in_piece_q;
    await_d    = await_q;
    rep_d      = rep_q;

    out_d.active_count    = count;
    out_d.event_flag      = 1'b0;
    out_d.marker_kind     = KIND_SINGLE;
    out_d.marker_position = '0;

    if (in_data_i.opcode == OP_RESTART) begin
      progress_d = '0;
      start_d    = '0;
      first_d    = '0;
      on_d       = '0;
      off_d      = '0;
      in_piece_d = 1'b0;
      await_d    = 1'b0;
      rep_d      = 1'b0;
      out_d.active_count = '0;
    end else if (!in_piece_q) begin
      off_d = '0;
      if (tape) begin
        if (on_inc >= confirm_q) begin
          in_piece_d = 1'b1;
          on_d       = '0;
          start_d    = progress_d;
        end else begin
          on_d = on_inc;
        end
      end else begin
        on_d = '0;
      end
      // no second piece in reach: report the first one alone
      if (kind_q == KIND_DOUBLE && await_q && timeout && !rep_q) begin
        rep_d                 = 1'b1;
        out_d.event_flag      = 1'b1;
        out_d.marker_kind     = KIND_SINGLE;
        out_d.marker_position = first_q;
      end
    end else begin
      on_d = '0;
      if (!tape) begin
        if (off_inc >= release_q) begin
          in_piece_d = 1'b0;
          off_d      = '0;
          if (!await_q) begin
            if (kind_q == KIND_SINGLE) begin
              if (!rep_q) begin
                rep_d                 = 1'b1;
                out_d.event_flag      = 1'b1;
                out_d.marker_kind     = KIND_SINGLE;
                out_d.marker_position = center;
              end
            end else begin
              first_d = center;
              await_d = 1'b1;
            end
          end else if (matched) begin
            if (!rep_q) begin
              rep_d                 = 1'b1;
              out_d.event_flag      = 1'b1;
              out_d.marker_kind     = KIND_DOUBLE;
              out_d.marker_position = mid;
            end
          end else begin
            first_d = center;
          end
        end else begin
          off_d = off_inc;
        end
      end else begin
        off_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_SINGLE;
      min_act_q <= 3'd1;
      confirm_q <= 8'd1;
      release_q <= 8'd1;
      dist_q    <= '0;
      tol_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_KIND:   kind_q    <= cfg_data_i[0];
        CFG_MIN_ACTIVE:      min_act_q <= cfg_data_i[2:0];
        CFG_CONFIRM_SAMPLES: confirm_q <= cfg_data_i[7:0];
        CFG_RELEASE_SAMPLES: release_q <= cfg_data_i[7:0];
        CFG_PAIR_DISTANCE:   dist_q    <= cfg_data_i;
        CFG_PAIR_TOLERANCE:  tol_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q  <= '0;
      start_q     <= '0;
      first_q     <= '0;
      on_q        <= '0;
      off_q       <= '0;
      in_piece_q  <= 1'b0;
      await_q     <= 1'b0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        progress_q <= progress_d;
        start_q    <= start_d;
        first_q    <= first_d;
        on_q       <= on_d;
        off_q      <= off_d;
        in_piece_q <= in_piece_d;
        await_q    <= await_d;
        rep_q      <= rep_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tape marker detector. A clocked driver feeds
// sample and restart requests from a pending queue, and a clocked monitor
// predicts each accepted request and compares every result field in order.
// Phases cover default, single and double marker setups, saturating
// counters, odd register values, long travel strides and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import tmd_pkg::*;

  localparam int QuietLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_req_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_req_t             out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  tape_marker_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // detector setup as the bench sees it
  logic        reg_kind    = KIND_SINGLE;
  logic [2:0]  reg_min_ch  = 3'd1;
  logic [7:0]  reg_confirm = 8'd1;
  logic [7:0]  reg_release = 8'd1;
  logic [15:0] reg_gap_nom = '0;
  logic [15:0] reg_gap_tol = '0;

  // tracking state
  logic [31:0] pos_acc     = '0;
  logic [31:0] piece_begin = '0;
  logic [31:0] first_mid   = '0;
  logic [7:0]  tape_run    = '0;
  logic [7:0]  gap_run     = '0;
  logic        on_tape     = 1'b0;
  logic        want_second = 1'b0;
  logic        marker_sent = 1'b0;

  in_req_t  sample_q[$];
  out_req_t marker_exp_q[$];

  int   n_queued     = 0;
  int   n_taken      = 0;
  int   n_fail       = 0;
  int   quiet_cycles = 0;
  int   idle_odds    = 6;
  int   src_gap      = 0;
  int   sink_gap     = 0;
  int   sink_hold    = 0;
  logic in_fire      = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] half_of(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  function automatic void post_marker(inout out_req_t res, input logic kind,
                                      input logic [31:0] pos);
    if (marker_sent) return;
    marker_sent         = 1'b1;
    res.event_flag      = 1'b1;
    res.marker_kind     = kind;
    res.marker_position = pos;
  endfunction

  function automatic out_req_t track_sample(in_req_t rq);
    out_req_t   res;
    logic [2:0] cnt;
    logic       is_tape;
    logic [31:0] mid;
    longint     lead, lim, spread;
    res = '0;
    if (rq.opcode == OP_RESTART) begin
      pos_acc     = '0;
      piece_begin = '0;
      first_mid   = '0;
      tape_run    = '0;
      gap_run     = '0;
      on_tape     = 1'b0;
      want_second = 1'b0;
      marker_sent = 1'b0;
      return res;
    end
    pos_acc = pos_acc + {{16{rq.travel_step[15]}}, rq.travel_step};
    cnt = 3'($countones(rq.sensor_bits));
    is_tape = (cnt >= reg_min_ch);
    res.active_count = cnt;
    if (!on_tape) begin
      gap_run = '0;
      if (is_tape) begin
        if (tape_run != SatMax) tape_run++;
        if (tape_run >= reg_confirm) begin
          on_tape     = 1'b1;
          tape_run    = '0;
          piece_begin = pos_acc;
        end
      end else begin
        tape_run = '0;
      end
      lead = longint'($signed(pos_acc)) - longint'($signed(first_mid));
      lim  = longint'(reg_gap_nom) + longint'(reg_gap_tol);
      if (reg_kind == KIND_DOUBLE && want_second && lead > lim) begin
        post_marker(res, KIND_SINGLE, first_mid);
      end
    end else begin
      tape_run = '0;
      if (!is_tape) begin
        if (gap_run != SatMax) gap_run++;
        if (gap_run >= reg_release) begin
          on_tape = 1'b0;
          gap_run = '0;
          mid = half_of(piece_begin, pos_acc);
          if (!want_second) begin
            if (reg_kind == KIND_SINGLE) begin
              post_marker(res, KIND_SINGLE, mid);
            end else begin
              first_mid   = mid;
              want_second = 1'b1;
            end
          end else begin
            spread = longint'($signed(mid)) - longint'($signed(first_mid))
                     - longint'(reg_gap_nom);
            if (spread < 0) spread = -spread;
            if (spread <= longint'(reg_gap_tol)) begin
              post_marker(res, KIND_DOUBLE, half_of(first_mid, mid));
            end else begin
              first_mid = mid;
            end
          end
        end
      end else begin
        gap_run = '0;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_data_i  <= sample_q.pop_front();
        in_valid_i <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          src_gap = $urandom_range(1, 16);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        sink_gap = $urandom_range(1, 16);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    out_req_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (marker_exp_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        end else begin
          want = marker_exp_q.pop_front();
          check_field("active_count", want.active_count, out_data_o.active_count);
          check_field("event_flag", want.event_flag, out_data_o.event_flag);
          check_field("marker_kind", want.marker_kind, out_data_o.marker_kind);
          check_field("marker_position", want.marker_position,
                      out_data_o.marker_position);
        end
      end
      in_fire = in_valid_i && in_ready_o;
      if (in_fire) begin
        n_taken++;
        marker_exp_q.push_back(track_sample(in_data_i));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_sample(logic [3:0] bits, logic [15:0] step);
    in_req_t rq;
    rq.opcode      = OP_SAMPLE;
    rq.sensor_bits = bits;
    rq.travel_step = step;
    sample_q.push_back(rq);
    n_queued++;
  endfunction

  function automatic void add_restart();
    in_req_t rq;
    rq.opcode      = OP_RESTART;
    rq.sensor_bits = 4'($urandom);
    rq.travel_step = 16'($urandom);
    sample_q.push_back(rq);
    n_queued++;
  endfunction

  // sensor pattern that does or does not count as tape
  function automatic logic [3:0] tape_bits(logic want_tape);
    logic [3:0] b;
    for (int k = 0; k < 8; k++) begin
      b = 4'($urandom);
      if (($countones(b) >= reg_min_ch) == want_tape) return b;
    end
    return want_tape ? 4'hF : 4'h0;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EXPECTED_KIND:   reg_kind    = val[0];
      CFG_MIN_ACTIVE:      reg_min_ch  = val[2:0];
      CFG_CONFIRM_SAMPLES: reg_confirm = val[7:0];
      CFG_RELEASE_SAMPLES: reg_release = val[7:0];
      CFG_PAIR_DISTANCE:   reg_gap_nom = val;
      CFG_PAIR_TOLERANCE:  reg_gap_tol = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic kind, input logic [2:0] min_ch,
                          input logic [7:0] conf, input logic [7:0] rel,
                          input logic [15:0] nom, input logic [15:0] tol);
    write_reg(CFG_EXPECTED_KIND, 16'(kind));
    write_reg(CFG_MIN_ACTIVE, 16'(min_ch));
    write_reg(CFG_CONFIRM_SAMPLES, 16'(conf));
    write_reg(CFG_RELEASE_SAMPLES, 16'(rel));
    write_reg(CFG_PAIR_DISTANCE, nom);
    write_reg(CFG_PAIR_TOLERANCE, tol);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (n_taken != n_queued || marker_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n_items, input int odds, input int hold);
    int          goal, len_on, len_off, span, pieces, tail;
    int unsigned step_mag;
    logic [15:0] stepv;
    @(posedge clk_i);
    idle_odds = odds;
    sink_hold = hold;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 12)) add_sample(4'($urandom), 16'($urandom));
        3: add_restart();
        default: begin
          // one or two tape pieces with a fixed step
          len_on = reg_confirm + $urandom_range(0, 6);
          if (len_on == 0) len_on = 1;
          len_off = (reg_release == 0 ? 1 : reg_release) + $urandom_range(0, 4);
          if (reg_kind == KIND_DOUBLE) begin
            len_off += $urandom_range(0, 30);
            span = len_on + len_off;
            step_mag = (reg_gap_nom + span / 2) / span;
            case ($urandom_range(0, 5))
              0: step_mag = step_mag + 1;
              1: if (step_mag > 0) step_mag = step_mag - 1;
              default: ;
            endcase
            if (step_mag > 32767) step_mag = 32767;
            pieces = ($urandom_range(0, 4) == 0) ? 1 : 2;
            tail = (pieces == 1) ? 2 * span + 2 : $urandom_range(0, 6);
          end else begin
            step_mag = $urandom_range(0, 40);
            pieces = 1;
            tail = $urandom_range(0, 3);
          end
          stepv = 16'(step_mag);
          if ($urandom_range(0, 7) == 0) stepv = -stepv;
          repeat ($urandom_range(0, 3)) add_sample(tape_bits(1'b0), stepv);
          repeat (pieces) begin
            repeat (len_on) add_sample(tape_bits(1'b1), stepv);
            repeat (len_off) add_sample(tape_bits(1'b0), stepv);
          end
          repeat (tail) add_sample(tape_bits(1'b0), stepv);
          if ($urandom_range(0, 3) != 0) add_restart();
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single marker, default setup
    @(posedge clk_i);
    add_sample(4'h0, 16'd0);
    add_sample(4'hF, 16'h7FFF);
    add_sample(4'h0, 16'h8000);
    add_sample(4'hF, 16'd1);
    add_sample(4'h0, 16'd1);
    add_restart();
    add_sample(4'h1, 16'd10);
    add_sample(4'h2, 16'hFFFB);
    add_sample(4'h4, 16'd0);
    add_sample(4'h8, 16'hFFFF);
    add_sample(4'h0, 16'd3);
    add_restart();
    add_sample(4'hF, 16'd2);
    add_restart();
    add_sample(4'h0, 16'd0);
    wait_drained();

    // matched pair, then a lone piece that times out
    set_regs(KIND_DOUBLE, 3'd4, 8'd2, 8'd1, 16'd10, 16'd0);
    @(posedge clk_i);
    add_restart();
    add_sample(4'hF, 16'd1);
    add_sample(4'hF, 16'd1);
    add_sample(4'h0, 16'd1);
    repeat (7) add_sample(4'h7, 16'd1);
    add_sample(4'hF, 16'd1);
    add_sample(4'hF, 16'd1);
    add_sample(4'h0, 16'd1);
    add_restart();
    add_sample(4'hF, 16'd1);
    add_sample(4'hF, 16'd1);
    add_sample(4'h0, 16'd1);
    add_sample(4'h0, 16'd20);
    wait_drained();

    set_regs(KIND_SINGLE, 3'd1, 8'd1, 8'd1, 16'd0, 16'd0);
    random_phase(200, 4, 0);
    set_regs(KIND_DOUBLE, 3'd2, 8'd3, 8'd2, 16'd300, 16'd20);
    random_phase(250, 8, 300);
    set_regs(KIND_DOUBLE, 3'd3, 8'd1, 8'd4, 16'd0, 16'd0);
    random_phase(150, 3, 0);
    set_regs(KIND_SINGLE, 3'd4, 8'd255, 8'd255, 16'd0, 16'd0);
    random_phase(200, 40, 0);
    set_regs(KIND_DOUBLE, 3'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    random_phase(200, 10, 0);
    set_regs(KIND_DOUBLE, 3'd2, 8'd2, 8'd3, 16'd1000, 16'd0);
    random_phase(200, 5, 0);
    set_regs(KIND_SINGLE, 3'd0, 8'd0, 8'd0, 16'd77, 16'd3);
    random_phase(100, 6, 0);
    set_regs(KIND_DOUBLE, 3'd7, 8'd0, 8'd0, 16'd50, 16'd50);
    random_phase(60, 6, 0);

    // long strides, mostly in one direction
    set_regs(KIND_DOUBLE, 3'd1, 8'd1, 8'd1, 16'hFFFF, 16'd100);
    @(posedge clk_i);
    idle_odds = 32;
    add_restart();
    repeat (60) add_sample(4'h0, 16'h7FFF);
    repeat (80) begin
      add_sample(tape_bits(1'($urandom_range(0, 1))),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h7FFF);
    end
    wait_drained();

    set_regs(KIND_DOUBLE, 3'd1, 8'd1, 8'd2, 16'd40, 16'd5);
    random_phase(200, 0, 0);

    if (n_fail == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
